/* rtl/heap_sort_engine_macros.svh */
// assertion helpers shared by the checker
`ifndef HEAP_SORT_ENGINE_MACROS_SVH
`define HEAP_SORT_ENGINE_MACROS_SVH

// property checked on every clock edge outside reset
`define HSE_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// property checked on every clock edge, reset included
`define HSE_ASSERT_ALWAYS(name, prop, msg) \
   name: assert property (@(posedge clock) prop) else $error(msg);

`endif

/* rtl/hse_pkg.sv */
package hse_pkg;

   localparam int DefaultDepth     = 64;
   localparam int DefaultDataWidth = 32;

   // per-cycle command broadcast to every cell of the chain
   typedef struct packed {
      logic insert;   // a new element enters the sorted row
      logic shift;    // the row moves one place toward cell 0
   } cell_ctrl_type;

endpackage

/* rtl/hse_cell.sv */
module hse_cell
   import hse_pkg::*;
#(
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cell_ctrl_type                ctrl,
   input  logic signed [DATA_WIDTH-1:0] new_value,
   input  logic                         left_lt,
   input  logic signed [DATA_WIDTH-1:0] left_value,
   input  logic                         left_valid,
   input  logic signed [DATA_WIDTH-1:0] right_value,
   input  logic                         right_valid,
   output logic signed [DATA_WIDTH-1:0] value,
   output logic                         valid,
   output logic                         lt
);

   logic signed [DATA_WIDTH-1:0] value_ff, value_in;
   logic                         valid_ff, valid_in;

   // empty cells count as plus infinity
   assign lt = !valid_ff || (new_value < value_ff);

   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctrl.shift) begin
         value_in = right_value;
         valid_in = right_valid;
      end else if (ctrl.insert && lt) begin
         if (left_lt) begin
            value_in = left_value;
            valid_in = left_valid;
         end else begin
            value_in = new_value;
            valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule

/* rtl/heap_sort_engine.sv */
// sorting engine: a row of DEPTH compare cells kept in ascending order
// load: one element per cycle, req_ready high for the whole load phase
// the closing beat is inserted in its own cycle; the first result shows in the cycle after it
// drain: one result per cycle from cell 0 while rsp_ready is high, n results per set
// no element is taken during the drain; one set is sorted at a time
// reset (synchronous, active high) empties every cell and clears count and drop flag
module heap_sort_engine
   import hse_pkg::*;
#(
   parameter int DEPTH      = DefaultDepth,
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_sample_value,
   input  logic                         req_is_last,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   output logic                         rsp_last_out,
   output logic                         rsp_overflow
);

   localparam int CountWidth = $clog2(DEPTH + 1);

   // element count and state flags
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  drain_ff, drain_in;
   logic                  dropped_ff, dropped_in;

   logic          req_beat;
   logic          rsp_beat;
   logic          full;
   cell_ctrl_type ctrl;

   // neighbor wiring of the chain, one slot past the right end
   logic signed [DATA_WIDTH-1:0] cell_value [DEPTH+1];
   logic                         cell_valid [DEPTH+1];
   logic                         cell_lt    [DEPTH];

   assign req_ready = !drain_ff;
   assign req_beat  = req_valid && req_ready;
   assign rsp_beat  = rsp_valid && rsp_ready;
   assign full      = (count_ff == CountWidth'(DEPTH));

   // a full store drops the element instead of inserting it
   assign ctrl.insert = req_beat && !full;
   assign ctrl.shift  = rsp_beat;

   // past the right end the row reads as empty
   assign cell_value[DEPTH] = '0;
   assign cell_valid[DEPTH] = 1'b0;

   genvar i;
   generate
      for (i = 0; i < DEPTH; i++) begin : g_cell
         logic                         left_lt;
         logic signed [DATA_WIDTH-1:0] left_value;
         logic                         left_valid;

         if (i == 0) begin : g_head
            // nothing left of cell 0 can be pushed in
            assign left_lt    = 1'b0;
            assign left_value = '0;
            assign left_valid = 1'b0;
         end else begin : g_body
            assign left_lt    = cell_lt[i-1];
            assign left_value = cell_value[i-1];
            assign left_valid = cell_valid[i-1];
         end

         hse_cell #(
            .DATA_WIDTH (DATA_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_value   (req_sample_value),
            .left_lt     (left_lt),
            .left_value  (left_value),
            .left_valid  (left_valid),
            .right_value (cell_value[i+1]),
            .right_valid (cell_valid[i+1]),
            .value       (cell_value[i]),
            .valid       (cell_valid[i]),
            .lt          (cell_lt[i])
         );
      end
   endgenerate

   always_comb begin
      count_in   = count_ff;
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_beat) begin
         if (full) begin
            dropped_in = 1'b1;
         end else begin
            count_in = count_ff + CountWidth'(1);
         end
         // closing beat: switch to draining the sorted row
         if (req_is_last) begin
            drain_in = 1'b1;
         end
      end
      if (rsp_beat && rsp_last_out) begin
         // burst done, ready for the next set
         count_in   = '0;
         drain_in   = 1'b0;
         dropped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         drain_ff   <= 1'b0;
         dropped_ff <= 1'b0;
      end else begin
         count_ff   <= count_in;
         drain_ff   <= drain_in;
         dropped_ff <= dropped_in;
      end
   end

   // cell 0 always holds the smallest remaining element
   assign rsp_valid        = drain_ff && cell_valid[0];
   assign rsp_sorted_value = cell_value[0];
   assign rsp_last_out     = !cell_valid[1];
   assign rsp_overflow     = dropped_ff;

endmodule

/* rtl/hse_checker.sv */
`include "heap_sort_engine_macros.svh"

module hse_checker
   import hse_pkg::*;
#(
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   input logic                         rsp_last_out,
   input logic                         rsp_overflow
);

   logic                         in_burst_ff, in_burst_in;
   logic signed [DATA_WIDTH-1:0] prev_ff, prev_in;
   logic                         rsp_beat;

   assign rsp_beat = rsp_valid && rsp_ready;

   always_comb begin
      in_burst_in = in_burst_ff;
      prev_in     = prev_ff;
      if (rsp_beat) begin
         prev_in     = rsp_sorted_value;
         in_burst_in = !rsp_last_out;
      end
   end

   always_ff @(posedge clock) begin
      prev_ff <= prev_in;
      if (reset) begin
         in_burst_ff <= 1'b0;
      end else begin
         in_burst_ff <= in_burst_in;
      end
   end

   // results of one burst come out in ascending order
   `HSE_ASSERT(a_ascending, rsp_beat && in_burst_ff |-> rsp_sorted_value >= prev_ff, "results out of order")

   // no element is taken while a burst is being delivered
   `HSE_ASSERT(a_no_load_in_drain, rsp_valid |-> !req_ready, "load accepted during drain")

   // the overflow flag is the same on every result of a burst
   `HSE_ASSERT(a_overflow_steady, rsp_beat && !rsp_last_out |=> $stable(rsp_overflow), "overflow changed inside burst")

   // a stalled result stays put
   `HSE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_sorted_value), "stalled result changed")

   // reset leaves no result pending
   `HSE_ASSERT_ALWAYS(a_reset_quiet, reset |=> !rsp_valid, "result valid after reset")

endmodule

bind heap_sort_engine hse_checker #(
   .DATA_WIDTH (DATA_WIDTH)
) u_hse_checker (
   .clock            (clock),
   .reset            (reset),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_sorted_value (rsp_sorted_value),
   .rsp_last_out     (rsp_last_out),
   .rsp_overflow     (rsp_overflow)
);

/* tb/sv/sorted_stream_checker.sv */
module sorted_stream_checker
   import hse_pkg::*;
#(
   parameter int DEPTH      = DefaultDepth,
   parameter int DATA_WIDTH = DefaultDataWidth
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_ready,
   input  logic signed [DATA_WIDTH-1:0] req_sample_value,
   input  logic                         req_is_last,
   input  logic                         rsp_valid,
   input  logic                         rsp_ready,
   input  logic signed [DATA_WIDTH-1:0] rsp_sorted_value,
   input  logic                         rsp_last_out,
   input  logic                         rsp_overflow,
   output int                           error_count,
   output int                           pending_beats,
   output int                           beats_checked,
   output int                           sets_closed,
   output int                           overflow_sets
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] value;
      logic                         last;
      logic                         overflow;
   } sorted_beat_type;

   // elements of the open set, in arrival order
   logic signed [DATA_WIDTH-1:0] held_q[$];
   logic                         dropped;
   sorted_beat_type              sorted_due_q[$];

   task automatic report_mismatch(input string what);
      $display("tb mismatch @%0t: %s", $time, what);
      error_count++;
   endtask

   // sort the held set ascending and queue one beat per element
   task automatic queue_sorted_set();
      int                           i;
      int                           j;
      logic signed [DATA_WIDTH-1:0] key;
      sorted_beat_type              beat;
      for (i = 1; i < held_q.size(); i++) begin
         key = held_q[i];
         j   = i - 1;
         while (j >= 0 && held_q[j] > key) begin
            held_q[j+1] = held_q[j];
            j--;
         end
         held_q[j+1] = key;
      end
      for (i = 0; i < held_q.size(); i++) begin
         beat.value    = held_q[i];
         beat.last     = (i == held_q.size() - 1);
         beat.overflow = dropped;
         sorted_due_q.push_back(beat);
      end
      sets_closed++;
      if (dropped) overflow_sets++;
      held_q.delete();
      dropped = 1'b0;
   endtask

   always @(posedge clock) begin : monitor
      sorted_beat_type want;
      if (reset) begin
         held_q.delete();
         sorted_due_q.delete();
         dropped = 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (sorted_due_q.size() == 0) begin
               report_mismatch($sformatf("unexpected beat, value %0d", rsp_sorted_value));
            end else begin
               want = sorted_due_q.pop_front();
               beats_checked++;
               if (rsp_sorted_value !== want.value)
                  report_mismatch($sformatf("sorted_value got %0d want %0d",
                                            rsp_sorted_value, want.value));
               if (rsp_last_out !== want.last)
                  report_mismatch($sformatf("last_out got %b want %b", rsp_last_out, want.last));
               if (rsp_overflow !== want.overflow)
                  report_mismatch($sformatf("overflow got %b want %b",
                                            rsp_overflow, want.overflow));
            end
         end
         if (req_valid && req_ready) begin
            if (held_q.size() < DEPTH) held_q.push_back(req_sample_value);
            else dropped = 1'b1;
            if (req_is_last) queue_sorted_set();
         end
      end
      pending_beats = sorted_due_q.size();
   end

endmodule

/* tb/sv/tb_top.sv */
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import hse_pkg::*;

   localparam int Depth       = DefaultDepth;
   localparam int DataWidth   = DefaultDataWidth;
   localparam int RandomItems = 195;    // elements in generated sets, directed ones not counted
   localparam int HoldCycles  = 400;    // long receiver hold-off
   localparam int StallLimit  = 4000;   // cycles with no beat on either channel
   localparam int TailCycles  = 64;     // quiet time after the last expected beat

   localparam logic signed [DataWidth-1:0] SampleMax = {1'b0, {(DataWidth-1){1'b1}}};
   localparam logic signed [DataWidth-1:0] SampleMin = {1'b1, {(DataWidth-1){1'b0}}};

   logic                        clock = 1'b0;
   logic                        reset;
   logic                        req_valid;
   logic                        req_ready;
   logic signed [DataWidth-1:0] req_sample_value;
   logic                        req_is_last;
   logic                        rsp_valid;
   logic                        rsp_ready;
   logic signed [DataWidth-1:0] rsp_sorted_value;
   logic                        rsp_last_out;
   logic                        rsp_overflow;

   int error_count;
   int pending_beats;
   int beats_checked;
   int sets_closed;
   int overflow_sets;

   // handshake between stimulus and receiver for the long hold-off
   int hold_requests = 0;
   int holds_done    = 0;
   // sender burst bookkeeping
   int burst_left    = 0;
   int random_items  = 0;
   int stall_cycles  = 0;

   // 10 ns clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   heap_sort_engine dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow)
   );

   // watches both channels, predicts the sorted stream, counts mismatches
   sorted_stream_checker #(
      .DEPTH      (Depth),
      .DATA_WIDTH (DataWidth)
   ) u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_sample_value (req_sample_value),
      .req_is_last      (req_is_last),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_sorted_value (rsp_sorted_value),
      .rsp_last_out     (rsp_last_out),
      .rsp_overflow     (rsp_overflow),
      .error_count      (error_count),
      .pending_beats    (pending_beats),
      .beats_checked    (beats_checked),
      .sets_closed      (sets_closed),
      .overflow_sets    (overflow_sets)
   );

   // watchdog: restart on any accepted beat
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin : watchdog
      wait (stall_cycles >= StallLimit);
      $display("tb: watchdog expired after %0d idle cycles", StallLimit);
      $display("tb: failure");
      $finish;
   end

   // element picker: extremes, a narrow band for duplicates, or any word
   function automatic logic signed [DataWidth-1:0] pick_sample();
      unique case ($urandom_range(0, 7))
         0:       return SampleMax;
         1:       return SampleMin;
         2:       return $signed($urandom_range(0, 8)) - 4;
         default: return $urandom;
      endcase
   endfunction

   // one input beat; called at a falling edge, returns at a falling edge
   task automatic send_beat(input logic signed [DataWidth-1:0] value, input logic closing);
      int gap;
      // new burst: maybe drop valid for a random gap first
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 10);
         gap = $urandom_range(0, 7);
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      burst_left--;
      req_valid        <= 1'b1;
      req_sample_value <= value;
      req_is_last      <= closing;
      // hold the beat until the block takes it
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // a set of random elements, closed by its final beat
   task automatic send_set(input int size);
      int k;
      for (k = 0; k < size; k++) send_beat(pick_sample(), k == size - 1);
      random_items += size;
   endtask

   // sender pause until the whole sorted run has been taken
   task automatic wait_drained();
      while (pending_beats != 0) @(negedge clock);
   endtask

   // receiver: stretches of different ready patterns, plus the long hold-off
   initial begin : receiver
      int mode;
      int stretch;
      int i;
      rsp_ready = 1'b0;
      @(negedge clock);
      forever begin
         if (hold_requests != holds_done) begin
            // long hold-off while the sender keeps offering beats
            rsp_ready <= 1'b0;
            repeat (HoldCycles) @(negedge clock);
            holds_done++;
         end else begin
            mode    = $urandom_range(0, 4);
            stretch = $urandom_range(5, 40);
            for (i = 0; i < stretch; i++) begin
               unique case (mode)
                  1:       rsp_ready <= 1'($urandom_range(0, 1));
                  2:       rsp_ready <= ($urandom_range(0, 4) == 0);   // mostly stalled
                  3:       rsp_ready <= (i % 3 == 0);                  // ready when i is a multiple of 3
                  default: rsp_ready <= 1'b1;                          // no stalls
               endcase
               @(negedge clock);
            end
         end
      end
   end

   // stimulus and verdict
   initial begin : stimulus
      int size;
      reset            = 1'b1;
      req_valid        = 1'b0;
      req_sample_value = '0;
      req_is_last      = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // single-element sets at both extremes
      send_beat(SampleMax, 1'b1);
      send_beat(SampleMin, 1'b1);
      // mixed signs, both extremes and a repeated value in one set
      send_beat(0, 1'b0);
      send_beat(-1, 1'b0);
      send_beat(SampleMax, 1'b0);
      send_beat(1, 1'b0);
      send_beat(SampleMin, 1'b0);
      send_beat(-1, 1'b1);
      // all elements equal
      send_beat(5, 1'b0);
      send_beat(5, 1'b0);
      send_beat(5, 1'b1);
      // alternating bit patterns and near-extreme values
      send_beat(32'h5555_5555, 1'b0);
      send_beat(32'hAAAA_AAAA, 1'b0);
      send_beat(32'h8000_0001, 1'b0);
      send_beat(32'h7FFF_FFFE, 1'b1);
      wait_drained();

      // exactly full store, with the receiver held off so later beats back up
      hold_requests++;
      send_set(Depth);
      // one beyond depth: closing element dropped, overflow on every beat
      send_set(Depth + 1);
      wait_drained();

      // mostly short sets, now and then one around full depth
      while (random_items < RandomItems) begin
         if ($urandom_range(0, 11) == 0) size = $urandom_range(Depth - 2, Depth + 4);
         else size = $urandom_range(1, 8);
         if (size > RandomItems - random_items) size = RandomItems - random_items;
         send_set(size);
         if ($urandom_range(0, 3) == 0) wait_drained();
      end
      req_valid <= 1'b0;

      // drain, then stay quiet for a while to catch stray beats
      while (pending_beats != 0) @(negedge clock);
      repeat (TailCycles) @(negedge clock);

      $display("summary: %0d sets sorted, %0d of them with dropped elements",
               sets_closed, overflow_sets);
      $display("summary: %0d input elements in random sets, %0d sorted beats compared",
               random_items, beats_checked);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
